/* rtl/tdfc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdfc_pkg: shared types and constants
// Mode codes, register indexes, filter limits and the control word passed
// from the filter stage to the calibration stages.
// ----------------------------------------------------------------------------
package tdfc_pkg;

	localparam int RAW_BITS    = 12;
	localparam int CFG_WIDTH   = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int POS_WIDTH   = 16;
	localparam int DELTA_LIMIT = 2;
	localparam int FOCUS_LIMIT = 4;

	localparam logic [POS_WIDTH-1:0] NO_POS = 16'h7fff;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_A   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_B   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_C   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_D   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_E   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_F   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 3'd6;

	localparam logic [CFG_WIDTH-1:0] CAL_ONE = 32'h0001_0000;

	typedef enum logic [1:0] {
		MODE_NONE      = 2'd0,
		MODE_WAIT      = 2'd1,
		MODE_VALID     = 2'd2,
		MODE_PROCESSED = 2'd3
	} mode_t;

	typedef struct packed {
		logic                load;
		logic                clear;
		logic                fresh;
		mode_t               mode;
		logic [RAW_BITS-1:0] cal_x;
		logic [RAW_BITS-1:0] cal_y;
	} tdfc_ctrl_t;

endpackage
`default_nettype wire

/* rtl/tdfc_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdfc_filter: mode machine with delta and focus filtering
// Holds the mode, the two-sample history and the focus point, and decides
// for one word what the calibration stages and the output must do.
// ----------------------------------------------------------------------------
module tdfc_filter
	import tdfc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic                op,
	input  wire logic                pen,
	input  wire logic [RAW_BITS-1:0] sx,
	input  wire logic [RAW_BITS-1:0] sy,
	input  wire logic                present,
	output tdfc_ctrl_t               ctrl
);

	localparam int PW = RAW_BITS + 3;
	localparam logic signed [PW-1:0] DLIM = PW'(DELTA_LIMIT);
	localparam logic signed [PW-1:0] FLIM = PW'(FOCUS_LIMIT);

	mode_t               mode_q, mode_d;
	logic [RAW_BITS-1:0] hist1_x_q, hist1_y_q, hist2_x_q, hist2_y_q;
	logic [RAW_BITS-1:0] focus_x_q, focus_y_q;
	logic [RAW_BITS-1:0] hist1_x_d, hist1_y_d, hist2_x_d, hist2_y_d;
	logic [RAW_BITS-1:0] focus_x_d, focus_y_d;

	logic signed [PW-1:0] pred_x, pred_y, dlt_x, dlt_y, foc_x, foc_y;
	logic                 run, pass, focus_hit, load;

	// Linear prediction from the two previous samples, per axis.
	assign pred_x = (signed'(PW'(hist1_x_q)) <<< 1) - signed'(PW'(hist2_x_q));
	assign pred_y = (signed'(PW'(hist1_y_q)) <<< 1) - signed'(PW'(hist2_y_q));
	assign dlt_x  = pred_x - signed'(PW'(sx));
	assign dlt_y  = pred_y - signed'(PW'(sy));
	assign foc_x  = signed'(PW'(focus_x_q)) - signed'(PW'(sx));
	assign foc_y  = signed'(PW'(focus_y_q)) - signed'(PW'(sy));

	assign pass = (dlt_x <= DLIM) && (dlt_x >= -DLIM) && (dlt_y <= DLIM) && (dlt_y >= -DLIM);
	assign focus_hit = (foc_x <= FLIM) && (foc_x >= -FLIM) &&
		(foc_y <= FLIM) && (foc_y >= -FLIM);

	// A read always runs the sample step; a tick only with the panel present,
	// the pen down and the previous press not yet finished.
	assign run  = (op == OP_READ) || (present && pen && (mode_q != MODE_PROCESSED));
	assign load = run && (mode_q == MODE_WAIT) && pass;

	always_comb begin
		mode_d    = mode_q;
		hist1_x_d = hist1_x_q;
		hist1_y_d = hist1_y_q;
		hist2_x_d = hist2_x_q;
		hist2_y_d = hist2_y_q;
		focus_x_d = focus_x_q;
		focus_y_d = focus_y_q;
		if (run) begin
			unique case (mode_q)
				MODE_NONE: begin
					mode_d = MODE_WAIT;
				end
				MODE_WAIT: begin
					if (pass) begin
						mode_d = MODE_VALID;
						if (!focus_hit) begin
							focus_x_d = sx;
							focus_y_d = sy;
						end
					end else begin
						hist2_x_d = hist1_x_q;
						hist2_y_d = hist1_y_q;
						hist1_x_d = sx;
						hist1_y_d = sy;
					end
				end
				default: begin
				end
			endcase
		end
		if (op == OP_TICK) begin
			if (present && !pen && (mode_d == MODE_PROCESSED)) begin
				mode_d = MODE_NONE;
			end
		end else if (mode_d == MODE_VALID) begin
			mode_d = MODE_NONE;
		end
	end

	always_comb begin
		ctrl.load  = load;
		ctrl.clear = (op == OP_TICK) && present && !pen && (mode_q == MODE_PROCESSED);
		ctrl.fresh = (op == OP_READ) && (load || (mode_q == MODE_VALID));
		ctrl.mode  = mode_d;
		ctrl.cal_x = focus_hit ? focus_x_q : sx;
		ctrl.cal_y = focus_hit ? focus_y_q : sy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PROCESSED;
			hist1_x_q <= '0;
			hist1_y_q <= '0;
			hist2_x_q <= '0;
			hist2_y_q <= '0;
			focus_x_q <= '0;
			focus_y_q <= '0;
		end else if (take) begin
			mode_q    <= mode_d;
			hist1_x_q <= hist1_x_d;
			hist1_y_q <= hist1_y_d;
			hist2_x_q <= hist2_x_d;
			hist2_y_q <= hist2_y_d;
			focus_x_q <= focus_x_d;
			focus_y_q <= focus_y_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/tdfc_calib.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdfc_calib: one axis of the 16.16 affine calibration
// Registers the two coefficient products, then adds the offset and takes
// bits 16 to 31 of the sum as the calibrated coordinate.
// ----------------------------------------------------------------------------
module tdfc_calib
	import tdfc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [RAW_BITS-1:0]  x,
	input  wire logic [RAW_BITS-1:0]  y,
	input  wire logic [CFG_WIDTH-1:0] coef_x,
	input  wire logic [CFG_WIDTH-1:0] coef_y,
	input  wire logic [CFG_WIDTH-1:0] offset,
	output logic      [POS_WIDTH-1:0] pos
);

	logic [CFG_WIDTH-1:0] x_ext, y_ext, prod_x_s3, prod_y_s3, sum;

	assign x_ext = CFG_WIDTH'(x);
	assign y_ext = CFG_WIDTH'(y);

	// Only the low 32 bits of the exact sum reach the result, so the
	// products are kept modulo 2^32.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s3 <= coef_x * x_ext;
			prod_y_s3 <= coef_y * y_ext;
		end
	end

	assign sum = prod_x_s3 + prod_y_s3 + offset;
	assign pos = sum[CFG_WIDTH-1:CFG_WIDTH-POS_WIDTH];

endmodule
`default_nettype wire

/* rtl/touch_delta_focus_calibrate.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_delta_focus_calibrate: touch-panel filter and calibration
// Input words carry an opcode (tick or read), the pen flag and a raw sample.
// Every input word yields exactly one output word with the stored calibrated
// position, the pen mode, the fresh flag and the has-data flag.
//
// Both channels use valid/ready. A word passes four registers: the input
// register, the filter decision register (mode, history and focus update
// here), the product register and the output register, in that order.
// One word is accepted per cycle while the receiver does not stall; the
// filter state is updated as each word leaves the input register.
// When the receiver stalls, each stage still takes a word while the next
// stage has room, so four words are held before in_ready drops.
//
// Reset clears the pipeline, sets the mode to processed, the history and
// focus point to zero, the position to 32767, the calibration to identity
// and panel_present to one. Configuration writes take effect at once. The
// user must make them only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module touch_delta_focus_calibrate
	import tdfc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 opcode,
	input  wire logic                 pen_down,
	input  wire logic [RAW_BITS-1:0]  sample_x,
	input  wire logic [RAW_BITS-1:0]  sample_y,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [POS_WIDTH-1:0] pos_x,
	output logic signed [POS_WIDTH-1:0] pos_y,
	output logic [1:0]                pen_mode,
	output logic                      fresh_coords,
	output logic                      has_data
);

	logic [CFG_WIDTH-1:0] cal_a_q, cal_b_q, cal_c_q, cal_d_q, cal_e_q, cal_f_q;
	logic                 present_q;

	logic                v_s1, v_s2, v_s3;
	logic                rdy1, rdy2, rdy3, rdy4;
	logic                take1, take2, take3;
	logic                op_s1, pen_s1;
	logic [RAW_BITS-1:0] sx_s1, sy_s1;
	tdfc_ctrl_t          ctrl, ctrl_s2, ctrl_s3;
	logic [POS_WIDTH-1:0] cal_pos_x, cal_pos_y;
	logic [POS_WIDTH-1:0] out_x_q, out_y_q;
	mode_t               mode_s4;
	logic                fresh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q   <= CAL_ONE;
			cal_b_q   <= '0;
			cal_c_q   <= '0;
			cal_d_q   <= '0;
			cal_e_q   <= CAL_ONE;
			cal_f_q   <= '0;
			present_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CAL_A:   cal_a_q   <= cfg_wdata;
				REG_CAL_B:   cal_b_q   <= cfg_wdata;
				REG_CAL_C:   cal_c_q   <= cfg_wdata;
				REG_CAL_D:   cal_d_q   <= cfg_wdata;
				REG_CAL_E:   cal_e_q   <= cfg_wdata;
				REG_CAL_F:   cal_f_q   <= cfg_wdata;
				REG_PRESENT: present_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Each stage takes a new word when it is empty or its word moves on.
	assign rdy4     = !out_valid || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign take1    = v_s1 && rdy2;
	assign take2    = v_s2 && rdy3;
	assign take3    = v_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			op_s1  <= opcode;
			pen_s1 <= pen_down;
			sx_s1  <= sample_x;
			sy_s1  <= sample_y;
		end
		if (take1) ctrl_s2 <= ctrl;
		if (take2) ctrl_s3 <= ctrl_s2;
	end

	tdfc_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take1),
		.op      (op_s1),
		.pen     (pen_s1),
		.sx      (sx_s1),
		.sy      (sy_s1),
		.present (present_q),
		.ctrl    (ctrl)
	);

	tdfc_calib u_calib_x (
		.clk    (clk),
		.en     (take2),
		.x      (ctrl_s2.cal_x),
		.y      (ctrl_s2.cal_y),
		.coef_x (cal_a_q),
		.coef_y (cal_b_q),
		.offset (cal_c_q),
		.pos    (cal_pos_x)
	);

	tdfc_calib u_calib_y (
		.clk    (clk),
		.en     (take2),
		.x      (ctrl_s2.cal_x),
		.y      (ctrl_s2.cal_y),
		.coef_x (cal_d_q),
		.coef_y (cal_e_q),
		.offset (cal_f_q),
		.pos    (cal_pos_y)
	);

	// The output register also holds the stored position between words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_x_q  <= NO_POS;
			out_y_q  <= NO_POS;
			mode_s4  <= MODE_PROCESSED;
			fresh_s4 <= 1'b0;
		end else if (take3) begin
			if (ctrl_s3.load) begin
				out_x_q <= cal_pos_x;
				out_y_q <= cal_pos_y;
			end else if (ctrl_s3.clear) begin
				out_x_q <= NO_POS;
				out_y_q <= NO_POS;
			end
			mode_s4  <= ctrl_s3.mode;
			fresh_s4 <= ctrl_s3.fresh;
		end
	end

	assign pos_x        = signed'(out_x_q);
	assign pos_y        = signed'(out_y_q);
	assign pen_mode     = mode_s4;
	assign fresh_coords = fresh_s4;
	assign has_data     = (mode_s4 == MODE_VALID);

endmodule
`default_nettype wire

/* rtl/tdfc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdfc_checker: port-level checks for the touch filter
// Watches the top-level ports and flags inconsistent output words and
// unexpected back-pressure.
// ----------------------------------------------------------------------------
module tdfc_checker
	import tdfc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [POS_WIDTH-1:0] pos_x,
	input wire logic [POS_WIDTH-1:0] pos_y,
	input wire logic [1:0]           pen_mode,
	input wire logic                 fresh_coords,
	input wire logic                 has_data
);

	// A stalled output word must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y) &&
			$stable(pen_mode) && $stable(fresh_coords))
		else $error("stalled output word changed");

	// The input side only backs up when the receiver is stalling.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> has_data == (pen_mode == MODE_VALID))
		else $error("has_data disagrees with pen_mode");

	// Consumed data always leaves the mode at none.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fresh_coords |-> pen_mode == MODE_NONE)
		else $error("fresh coordinates with mode other than none");

endmodule

bind touch_delta_focus_calibrate tdfc_checker u_tdfc_checker (.*);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: touch_delta_focus_calibrate
// A directed sequence followed by random touch strokes drives the pen mode
// machine, the delta and focus filters and the affine calibration. The
// calibration is changed between phases, with the panel disabled in one phase.
// Every output word is compared with a cycle-free predictor.
// ----------------------------------------------------------------------------
module testbench;
	import tdfc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;

	typedef struct {
		logic [POS_WIDTH-1:0] pos_x;
		logic [POS_WIDTH-1:0] pos_y;
		mode_t                mode;
		logic                 fresh;
		logic                 has_data;
	} pen_report_t;

	// Tracks the pen state of the block and holds the reports it must produce.
	class pen_track_scoreboard;
		logic signed [CFG_WIDTH-1:0] cal_regs [6];
		logic                        present;
		mode_t                       mode;
		logic [RAW_BITS-1:0]         hist1_x, hist1_y, hist2_x, hist2_y;
		logic [RAW_BITS-1:0]         focus_x, focus_y;
		logic [POS_WIDTH-1:0]        held_x, held_y;
		pen_report_t                 expected_reports [$];
		int                          errors, checked;
		int                          n_fresh, n_delta_miss, n_focus_hold, n_focus_move;

		function new();
			cal_regs[REG_CAL_A] = CAL_ONE;
			cal_regs[REG_CAL_B] = '0;
			cal_regs[REG_CAL_C] = '0;
			cal_regs[REG_CAL_D] = '0;
			cal_regs[REG_CAL_E] = CAL_ONE;
			cal_regs[REG_CAL_F] = '0;
			present = 1'b1;
			mode = MODE_PROCESSED;
			hist1_x = '0; hist1_y = '0; hist2_x = '0; hist2_y = '0;
			focus_x = '0; focus_y = '0;
			held_x = NO_POS; held_y = NO_POS;
			errors = 0; checked = 0;
			n_fresh = 0; n_delta_miss = 0; n_focus_hold = 0; n_focus_move = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_WIDTH-1:0] data);
			if (idx == REG_PRESENT) begin
				present = data[0];
			end else begin
				cal_regs[idx] = data;
			end
		endfunction

		function int spread(int a, int b);
			return (a > b) ? a - b : b - a;
		endfunction

		// Bits 16..31 of the exact sum, which is the arithmetic shift wrapped to 16 bits.
		function logic [POS_WIDTH-1:0] affine(logic signed [CFG_WIDTH-1:0] m,
				logic signed [CFG_WIDTH-1:0] n, logic signed [CFG_WIDTH-1:0] o,
				logic [RAW_BITS-1:0] x, logic [RAW_BITS-1:0] y);
			longint acc;
			acc = longint'(m) * longint'(x) + longint'(n) * longint'(y) + longint'(o);
			return acc[31:16];
		endfunction

		function void filter_sample(logic [RAW_BITS-1:0] sx, logic [RAW_BITS-1:0] sy);
			int px, py;
			logic [RAW_BITS-1:0] ux, uy;
			if (mode == MODE_NONE) begin
				mode = MODE_WAIT;
				return;
			end
			if (mode != MODE_WAIT)
				return;
			px = 2 * int'(hist1_x) - int'(hist2_x);
			py = 2 * int'(hist1_y) - int'(hist2_y);
			if (spread(px, int'(sx)) <= DELTA_LIMIT && spread(py, int'(sy)) <= DELTA_LIMIT) begin
				if (spread(int'(focus_x), int'(sx)) <= FOCUS_LIMIT &&
						spread(int'(focus_y), int'(sy)) <= FOCUS_LIMIT) begin
					ux = focus_x;
					uy = focus_y;
					n_focus_hold++;
				end else begin
					focus_x = sx;
					focus_y = sy;
					ux = sx;
					uy = sy;
					n_focus_move++;
				end
				mode = MODE_VALID;
				held_x = affine(cal_regs[REG_CAL_A], cal_regs[REG_CAL_B], cal_regs[REG_CAL_C],
					ux, uy);
				held_y = affine(cal_regs[REG_CAL_D], cal_regs[REG_CAL_E], cal_regs[REG_CAL_F],
					ux, uy);
			end else begin
				hist2_x = hist1_x;
				hist2_y = hist1_y;
				hist1_x = sx;
				hist1_y = sy;
				n_delta_miss++;
			end
		endfunction

		function void take_sample(logic op, logic pen, logic [RAW_BITS-1:0] sx,
				logic [RAW_BITS-1:0] sy);
			pen_report_t r;
			r.fresh = 1'b0;
			if (op == OP_TICK) begin
				if (present) begin
					if (pen && mode != MODE_PROCESSED)
						filter_sample(sx, sy);
					if (!pen && mode == MODE_PROCESSED) begin
						mode = MODE_NONE;
						held_x = NO_POS;
						held_y = NO_POS;
					end
				end
			end else begin
				filter_sample(sx, sy);
				if (mode == MODE_VALID) begin
					mode = MODE_NONE;
					r.fresh = 1'b1;
					n_fresh++;
				end
			end
			r.pos_x = held_x;
			r.pos_y = held_y;
			r.mode = mode;
			r.has_data = (mode == MODE_VALID);
			expected_reports.push_back(r);
		endfunction

		task log_error(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_report(logic [POS_WIDTH-1:0] px, logic [POS_WIDTH-1:0] py,
				logic [1:0] pm, logic fr, logic hd);
			pen_report_t want;
			if (expected_reports.size() == 0) begin
				log_error("output word arrived with nothing expected");
				return;
			end
			want = expected_reports.pop_front();
			if (px !== want.pos_x)
				log_error($sformatf("word %0d pos_x %h, expected %h", checked, px, want.pos_x));
			if (py !== want.pos_y)
				log_error($sformatf("word %0d pos_y %h, expected %h", checked, py, want.pos_y));
			if (pm !== want.mode)
				log_error($sformatf("word %0d pen_mode %0d, expected %0d", checked, pm, want.mode));
			if (fr !== want.fresh)
				log_error($sformatf("word %0d fresh_coords %b, expected %b", checked, fr,
					want.fresh));
			if (hd !== want.has_data)
				log_error($sformatf("word %0d has_data %b, expected %b", checked, hd,
					want.has_data));
			checked++;
		endtask

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_WIDTH-1:0]  cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic                  opcode;
	logic                  pen_down;
	logic [RAW_BITS-1:0]   sample_x;
	logic [RAW_BITS-1:0]   sample_y;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [POS_WIDTH-1:0] pos_x;
	logic signed [POS_WIDTH-1:0] pos_y;
	logic [1:0]            pen_mode;
	logic                  fresh_coords;
	logic                  has_data;

	pen_track_scoreboard sb;
	int                  cycle_count;
	int                  words_sent;
	int                  settings_run;
	int                  disabled_words;
	bit                  no_idle;

	touch_delta_focus_calibrate uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.pen_down     (pen_down),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pen_mode     (pen_mode),
		.fresh_coords (fresh_coords),
		.has_data     (has_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d words still expected.", cycle_count,
				sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_report(pos_x, pos_y, pen_mode, fresh_coords, has_data);
	end

	// Receiver: random stalls per word, plus long hold-offs that back the
	// pipeline up into the input.
	initial begin
		int stall;
		int next_hold;
		out_ready = 1'b0;
		next_hold = 150;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (sb.checked >= next_hold) begin
				stall = $urandom_range(40, 80);
				next_hold += 400;
			end else if (no_idle) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 4);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(logic op, logic pen, int x, int y);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		pen_down <= pen;
		sample_x <= x[RAW_BITS-1:0];
		sample_y <= y[RAW_BITS-1:0];
		do @(posedge clk); while (!in_ready);
		sb.take_sample(op, pen, x[RAW_BITS-1:0], y[RAW_BITS-1:0]);
		words_sent++;
		if (op == OP_TICK && !sb.present)
			disabled_words++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic load_config(logic [CFG_WIDTH-1:0] a, logic [CFG_WIDTH-1:0] b,
			logic [CFG_WIDTH-1:0] c, logic [CFG_WIDTH-1:0] d, logic [CFG_WIDTH-1:0] e,
			logic [CFG_WIDTH-1:0] f, logic present);
		logic [CFG_WIDTH-1:0] vals [7];
		logic [CFG_IDX_W-1:0] idx;
		vals = '{a, b, c, d, e, f, {{(CFG_WIDTH-1){1'b0}}, present}};
		for (int i = 0; i < 7; i++) begin
			idx = i[CFG_IDX_W-1:0];
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= vals[i];
			sb.set_reg(idx, vals[i]);
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
		settings_run++;
	endtask

	function automatic int pick_coord();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return (1 << RAW_BITS) - 1;
			2: return $urandom_range(0, 3);
			3: return $urandom_range((1 << RAW_BITS) - 4, (1 << RAW_BITS) - 1);
			default: return $urandom_range(0, (1 << RAW_BITS) - 1);
		endcase
	endfunction

	function automatic int clamp_raw(int v);
		if (v < 0)
			return 0;
		if (v > (1 << RAW_BITS) - 1)
			return (1 << RAW_BITS) - 1;
		return v;
	endfunction

	// A held or slowly moving touch with small jitter; reads are mixed in so
	// the mode keeps cycling through wait, valid and none.
	task automatic trace_stroke(inout int budget);
		int bx, by, vx, vy, len, x, y;
		bx = pick_coord();
		by = pick_coord();
		vx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) - 2 : 0;
		vy = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) - 2 : 0;
		len = $urandom_range(3, 14);
		if ($urandom_range(0, 2) == 0) begin
			send_word(OP_TICK, 1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095));
			budget--;
		end
		for (int k = 0; k < len; k++) begin
			x = clamp_raw(bx + k * vx + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) - 3 : 0));
			y = clamp_raw(by + k * vy + (($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) - 3 : 0));
			if ($urandom_range(0, 3) == 0)
				send_word(OP_READ, 1'($urandom_range(0, 1)), x, y);
			else
				send_word(OP_TICK, 1'b1, x, y);
			budget--;
		end
		if ($urandom_range(0, 1) == 0) begin
			send_word(OP_READ, 1'($urandom_range(0, 1)), bx, by);
			budget--;
		end
	endtask

	task automatic random_words(int count);
		int budget;
		budget = count;
		while (budget > 0) begin
			case ($urandom_range(0, 9))
				7, 8: begin
					send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						$urandom_range(0, 4095), $urandom_range(0, 4095));
					budget--;
				end
				9: begin
					send_word(OP_TICK, 1'b0, pick_coord(), pick_coord());
					budget--;
				end
				default: trace_stroke(budget);
			endcase
		end
	endtask

	// Walks the mode machine from reset: the one-time exit from processed,
	// delta misses that fill the history, focus hold and focus move, and
	// reads in every mode.
	task automatic directed_words();
		send_word(OP_READ, 1'b1, 4095, 4095);
		send_word(OP_TICK, 1'b1, 0, 0);
		send_word(OP_TICK, 1'b0, 4095, 0);
		send_word(OP_TICK, 1'b0, 0, 4095);
		send_word(OP_TICK, 1'b1, 1234, 567);
		send_word(OP_TICK, 1'b1, 0, 0);
		send_word(OP_TICK, 1'b0, 99, 99);
		send_word(OP_READ, 1'b0, 4095, 4095);
		send_word(OP_READ, 1'b0, 2048, 2048);
		send_word(OP_TICK, 1'b1, 4095, 4095);
		send_word(OP_TICK, 1'b1, 4095, 4095);
		send_word(OP_TICK, 1'b1, 4095, 4095);
		send_word(OP_TICK, 1'b1, 0, 0);
		send_word(OP_READ, 1'b1, 4095, 4095);
		send_word(OP_TICK, 1'b1, 7, 7);
		send_word(OP_TICK, 1'b1, 4093, 4095);
		send_word(OP_READ, 1'b1, 0, 0);
		send_word(OP_READ, 1'b1, 4092, 4095);
		send_word(OP_READ, 1'b1, 4092, 4095);
		send_word(OP_READ, 1'b0, 4090, 4094);
		send_word(OP_TICK, 1'b1, 0, 4095);
		send_word(OP_TICK, 1'b1, 4087, 4095);
		send_word(OP_READ, 1'b0, 2730, 1365);
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		words_sent = 0;
		settings_run = 1;
		disabled_words = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		opcode = OP_TICK;
		pen_down = 1'b0;
		sample_x = '0;
		sample_y = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_words();
		random_words(300);

		drain_pipeline();
		load_config(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
		random_words(250);

		drain_pipeline();
		no_idle = 1'b1;
		load_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			1'b1);
		random_words(250);

		// Panel disabled: ticks must leave the state alone, reads still act.
		drain_pipeline();
		no_idle = 1'b0;
		load_config(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		random_words(80);

		drain_pipeline();
		load_config(32'sd52000, -32'sd3100, -32'sd4000000, 32'sd2500, 32'sd61000,
			32'sd7000000, 1'b1);
		random_words(300);

		drain_pipeline();
		load_config(-CAL_ONE, $urandom_range(0, 65535), $urandom(), 32'h0, -(CAL_ONE << 3),
			$urandom(), 1'b1);
		random_words(250);

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run covered %0d words under %0d calibration settings, %0d ticks with the panel off.",
			words_sent, settings_run, disabled_words);
		$display("Filter saw %0d delta misses, %0d focus holds, %0d focus moves, %0d fresh reads.",
			sb.n_delta_miss, sb.n_focus_hold, sb.n_focus_move, sb.n_fresh);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
